// File: rtl/x86e_pkg.sv
// Package for the x86-64 code emitter: payload structs, command and status codes,
// the descriptor passed from the front to the back, and the byte tables.
// Used by every module of the block; it depends on nothing.
package x86e_pkg;

  localparam int OffW = 17;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  localparam logic [3:0] CmdNop       = 4'd0;
  localparam logic [3:0] CmdMovImm    = 4'd1;
  localparam logic [3:0] CmdMovReg    = 4'd2;
  localparam logic [3:0] CmdAddImm    = 4'd3;
  localparam logic [3:0] CmdAddReg    = 4'd4;
  localparam logic [3:0] CmdSubImm    = 4'd5;
  localparam logic [3:0] CmdSubReg    = 4'd6;
  localparam logic [3:0] CmdMulReg    = 4'd7;
  localparam logic [3:0] CmdXorReg    = 4'd8;
  localparam logic [3:0] CmdLoopStart = 4'd9;
  localparam logic [3:0] CmdLoopDec   = 4'd10;
  localparam logic [3:0] CmdFinish    = 4'd11;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusSmall = 2'd1;
  localparam logic [1:0] StatusOvf   = 2'd2;

  localparam int PrologueLen = 13;
  localparam int EpilogueLen = 11;
  localparam int MinBuffer   = 64;
  localparam int Headroom    = 16;

  localparam logic [7:0] RexW = 8'h48;

  typedef struct packed {
    logic [3:0]  command;
    logic [3:0]  dest_reg;
    logic [3:0]  src_reg;
    logic [31:0] immediate;
    logic        last_item;
  } in_t;

  typedef struct packed {
    logic [7:0]      code_byte;
    logic [OffW-1:0] byte_offset;
    logic            last_of_run;
    logic            program_done;
    logic [1:0]      status;
  } out_t;

  // One request's worth of work for the back end.
  typedef struct packed {
    logic            pro;
    logic            err;
    logic [1:0]      status;
    logic [3:0]      cmd;
    logic [3:0]      dreg;
    logic [3:0]      sreg;
    logic [31:0]     imm;
    logic            shrt;
    logic [3:0]      len;
    logic            epi;
    logic [OffW-1:0] start;
  } desc_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_PRO,
    PH_BODY,
    PH_ERR,
    PH_EPI
  } phase_e;

  function automatic logic [7:0] prologue_byte(logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h55;
      4'd1:    b = 8'h48;
      4'd2:    b = 8'h89;
      4'd3:    b = 8'hE5;
      4'd4:    b = 8'h53;
      4'd5:    b = 8'h41;
      4'd6:    b = 8'h54;
      4'd7:    b = 8'h41;
      4'd8:    b = 8'h55;
      4'd9:    b = 8'h41;
      4'd10:   b = 8'h56;
      4'd11:   b = 8'h41;
      4'd12:   b = 8'h57;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] epilogue_byte(logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h41;
      4'd1:    b = 8'h5F;
      4'd2:    b = 8'h41;
      4'd3:    b = 8'h5E;
      4'd4:    b = 8'h41;
      4'd5:    b = 8'h5D;
      4'd6:    b = 8'h41;
      4'd7:    b = 8'h5C;
      4'd8:    b = 8'h5B;
      4'd9:    b = 8'h5D;
      4'd10:   b = 8'hC3;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] imm_byte(logic [31:0] imm, logic [1:0] k);
    return imm[8*k +: 8];
  endfunction

  // Byte idx of an instruction body. For loop_dec the imm field carries the
  // jump displacement already worked out by the front end.
  function automatic logic [7:0] body_byte(logic [3:0] cmd, logic [3:0] d, logic [3:0] s,
                                           logic [31:0] imm, logic shrt, logic [3:0] idx);
    logic [7:0] rex_d;
    logic [7:0] rex_sd;
    logic [7:0] rex_ds;
    logic [7:0] mod_sd;
    logic [7:0] mod_ds;
    logic [7:0] imm3;
    logic [7:0] imm5;
    logic [7:0] b;
    rex_d  = RexW | {7'b0, d[3]};
    rex_sd = RexW | {5'b0, s[3], 1'b0, d[3]};
    rex_ds = RexW | {5'b0, d[3], 1'b0, s[3]};
    mod_sd = {2'b11, s[2:0], d[2:0]};
    mod_ds = {2'b11, d[2:0], s[2:0]};
    imm3   = imm_byte(imm, 2'(idx - 4'd3));
    imm5   = imm_byte(imm, 2'(idx - 4'd5));
    b      = 8'h00;
    unique case (cmd)
      CmdNop: b = 8'h90;
      CmdMovImm, CmdAddImm, CmdSubImm: begin
        unique case (idx)
          4'd0:    b = rex_d;
          4'd1:    b = (cmd == CmdMovImm) ? 8'hC7 : 8'h81;
          4'd2:    b = (cmd == CmdSubImm) ? {5'b11101, d[2:0]} : {5'b11000, d[2:0]};
          default: b = imm3;
        endcase
      end
      CmdMovReg, CmdAddReg, CmdSubReg, CmdXorReg: begin
        unique case (idx)
          4'd0: b = rex_sd;
          4'd1: begin
            unique case (cmd)
              CmdMovReg: b = 8'h89;
              CmdAddReg: b = 8'h01;
              CmdSubReg: b = 8'h29;
              default:   b = 8'h31;
            endcase
          end
          default: b = mod_sd;
        endcase
      end
      CmdMulReg: begin
        unique case (idx)
          4'd0:    b = rex_ds;
          4'd1:    b = 8'h0F;
          4'd2:    b = 8'hAF;
          default: b = mod_ds;
        endcase
      end
      CmdLoopDec: begin
        unique case (idx)
          4'd0:    b = rex_d;
          4'd1:    b = 8'hFF;
          4'd2:    b = {5'b11001, d[2:0]};
          4'd3:    b = shrt ? 8'h75 : 8'h0F;
          4'd4:    b = shrt ? imm[7:0] : 8'h85;
          default: b = imm5;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/x86e_front.sv
// Front end of the x86-64 code emitter: accepts items, keeps the program state and the
// buffer size register, and turns each item that emits bytes into a descriptor for the queue.
// Depends on x86e_pkg.
module x86e_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  x86e_pkg::in_t               in_data_i,
  input  logic                        cfg_we_i,
  input  logic [15:0]                 cfg_wdata_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output x86e_pkg::desc_t             q_desc_o
);

  localparam int OW = x86e_pkg::OffW;
  localparam int RW = OW + 1;
  localparam int CW = (OW + 1 > 17) ? OW + 1 : 17;

  logic [15:0]   bs_q;
  logic [OW-1:0] wo_q, wo_d;
  logic [OW-1:0] ls_q, ls_d;
  logic          inp_q, inp_d;
  logic          skip_q, skip_d;

  logic                 accept;
  logic                 pro, too_small, ovf, shrt, epi, last;
  logic [OW-1:0]        w, ls_cur;
  logic signed [RW-1:0] diff5, diff9;
  logic [3:0]           len;
  logic [3:0]           cmd;

  function automatic logic [3:0] body_len(logic [3:0] c, logic s);
    logic [3:0] n;
    unique case (c)
      x86e_pkg::CmdNop:                                           n = 4'd1;
      x86e_pkg::CmdMovImm, x86e_pkg::CmdAddImm, x86e_pkg::CmdSubImm: n = 4'd7;
      x86e_pkg::CmdMovReg, x86e_pkg::CmdAddReg, x86e_pkg::CmdSubReg,
      x86e_pkg::CmdXorReg:                                        n = 4'd3;
      x86e_pkg::CmdMulReg:                                        n = 4'd4;
      x86e_pkg::CmdLoopDec:                                       n = s ? 4'd5 : 4'd9;
      default:                                                    n = 4'd0;
    endcase
    return n;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign cmd        = in_data_i.command;
  assign last       = in_data_i.last_item;

  always_comb begin
    too_small = !inp_q && (bs_q < 16'(x86e_pkg::MinBuffer));
    pro       = !inp_q;
    w         = pro ? OW'(x86e_pkg::PrologueLen) : wo_q;
    ls_cur    = pro ? OW'(x86e_pkg::PrologueLen) : ls_q;
    ovf       = (CW'(w) + CW'(x86e_pkg::Headroom)) >= CW'(bs_q);
    // Displacements from the end of the short and the long jnz back to the loop start.
    diff5     = $signed({1'b0, ls_cur}) - $signed({1'b0, w}) - RW'(5);
    diff9     = diff5 - RW'(4);
    shrt      = (diff5 >= -128) && (diff5 <= 127);
    len       = body_len(cmd, shrt);
    epi       = (cmd == x86e_pkg::CmdFinish) || last;

    q_desc_o.pro    = pro && !too_small;
    q_desc_o.err    = too_small || ovf;
    q_desc_o.status = too_small ? x86e_pkg::StatusSmall : x86e_pkg::StatusOvf;
    q_desc_o.cmd    = cmd;
    q_desc_o.dreg   = in_data_i.dest_reg;
    q_desc_o.sreg   = in_data_i.src_reg;
    q_desc_o.imm    = (cmd == x86e_pkg::CmdLoopDec) ? (shrt ? 32'(diff5) : 32'(diff9))
                                                    : in_data_i.immediate;
    q_desc_o.shrt   = shrt;
    q_desc_o.len    = (too_small || ovf) ? 4'd0 : len;
    q_desc_o.epi    = epi && !(too_small || ovf);
    q_desc_o.start  = pro ? '0 : wo_q;
  end

  always_comb begin
    wo_d     = wo_q;
    ls_d     = ls_q;
    inp_d    = inp_q;
    skip_d   = skip_q;
    q_push_o = 1'b0;
    if (accept) begin
      if (inp_q && skip_q) begin
        if (last) begin
          inp_d  = 1'b0;
          skip_d = 1'b0;
        end
      end else if (too_small) begin
        q_push_o = 1'b1;
        inp_d    = !last;
        skip_d   = !last;
      end else begin
        wo_d   = w;
        ls_d   = ls_cur;
        inp_d  = 1'b1;
        skip_d = 1'b0;
        if (ovf) begin
          q_push_o = 1'b1;
          inp_d    = !last;
          skip_d   = !last;
        end else begin
          q_push_o = pro || (len != 4'd0) || epi;
          wo_d     = OW'(w + OW'(len) + (epi ? OW'(x86e_pkg::EpilogueLen) : OW'(0)));
          if (cmd == x86e_pkg::CmdLoopStart) begin
            ls_d = w;
          end
          if (cmd == x86e_pkg::CmdFinish) begin
            inp_d  = !last;
            skip_d = !last;
          end else if (last) begin
            inp_d  = 1'b0;
            skip_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q   <= 16'd4096;
      wo_q   <= '0;
      ls_q   <= OW'(x86e_pkg::PrologueLen);
      inp_q  <= 1'b0;
      skip_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bs_q <= cfg_wdata_i;
      end
      wo_q   <= wo_d;
      ls_q   <= ls_d;
      inp_q  <= inp_d;
      skip_q <= skip_d;
    end
  end

endmodule

// File: rtl/x86e_queue.sv
// Short descriptor queue between the front and the back of the code emitter.
// Depends on x86e_pkg for the descriptor type and the depth.
module x86e_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  x86e_pkg::desc_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output x86e_pkg::desc_t rdata_o
);

  localparam int PW = x86e_pkg::QPtrW;

  x86e_pkg::desc_t mem_q [x86e_pkg::QDepth];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(x86e_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= PW'(wp_q + 1'b1);
      end
      if (do_pop) begin
        rp_q <= PW'(rp_q + 1'b1);
      end
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

// File: rtl/x86e_back.sv
// Back end of the code emitter: walks the prologue, body, error and epilogue
// phases of the queue head, one byte per cycle while the output is not stalled, into the output register.
// Depends on x86e_pkg.
module x86e_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            hv_i,
  input  x86e_pkg::desc_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output x86e_pkg::out_t  out_data_o
);

  localparam int OW = x86e_pkg::OffW;

  x86e_pkg::phase_e ph_q, ph_d, eff_ph, nxt_ph;
  logic [3:0]       idx_q, idx_d;
  logic [OW-1:0]    off_q, off_d, eff_off;
  logic             step, ph_end, fin;
  logic             ov_q;
  x86e_pkg::out_t   out_q, byte_d;

  assign step = hv_i && (!ov_q || out_ready_i);

  // Phase and offset in effect this cycle; a fresh head resolves its first phase here.
  always_comb begin
    eff_ph  = ph_q;
    eff_off = off_q;
    if (ph_q == x86e_pkg::PH_START) begin
      eff_off = head_i.start;
      if (head_i.pro) begin
        eff_ph = x86e_pkg::PH_PRO;
      end else if (head_i.err) begin
        eff_ph = x86e_pkg::PH_ERR;
      end else if (head_i.len != 4'd0) begin
        eff_ph = x86e_pkg::PH_BODY;
      end else begin
        eff_ph = x86e_pkg::PH_EPI;
      end
    end
  end

  // Next state.
  always_comb begin
    ph_end = 1'b0;
    nxt_ph = x86e_pkg::PH_START;
    unique case (eff_ph)
      x86e_pkg::PH_PRO: begin
        ph_end = (idx_q == 4'(x86e_pkg::PrologueLen - 1));
        if (head_i.err) begin
          nxt_ph = x86e_pkg::PH_ERR;
        end else if (head_i.len != 4'd0) begin
          nxt_ph = x86e_pkg::PH_BODY;
        end else if (head_i.epi) begin
          nxt_ph = x86e_pkg::PH_EPI;
        end
      end
      x86e_pkg::PH_BODY: begin
        ph_end = (idx_q == head_i.len - 4'd1);
        if (head_i.epi) begin
          nxt_ph = x86e_pkg::PH_EPI;
        end
      end
      x86e_pkg::PH_ERR: ph_end = 1'b1;
      x86e_pkg::PH_EPI: ph_end = (idx_q == 4'(x86e_pkg::EpilogueLen - 1));
      default: ph_end = 1'b1;
    endcase
    fin   = ph_end && (nxt_ph == x86e_pkg::PH_START);
    ph_d  = ph_q;
    idx_d = idx_q;
    off_d = off_q;
    pop_o = 1'b0;
    if (step) begin
      off_d = OW'(eff_off + 1'b1);
      if (fin) begin
        ph_d  = x86e_pkg::PH_START;
        idx_d = 4'd0;
        pop_o = 1'b1;
      end else if (ph_end) begin
        ph_d  = nxt_ph;
        idx_d = 4'd0;
      end else begin
        ph_d  = eff_ph;
        idx_d = idx_q + 4'd1;
      end
    end
  end

  // Output byte.
  always_comb begin
    byte_d.byte_offset  = eff_off;
    byte_d.last_of_run  = fin;
    byte_d.program_done = 1'b0;
    byte_d.status       = x86e_pkg::StatusOk;
    unique case (eff_ph)
      x86e_pkg::PH_PRO:  byte_d.code_byte = x86e_pkg::prologue_byte(idx_q);
      x86e_pkg::PH_BODY: byte_d.code_byte = x86e_pkg::body_byte(head_i.cmd, head_i.dreg,
                                              head_i.sreg, head_i.imm, head_i.shrt, idx_q);
      x86e_pkg::PH_EPI: begin
        byte_d.code_byte    = x86e_pkg::epilogue_byte(idx_q);
        byte_d.program_done = ph_end;
      end
      default: begin
        byte_d.code_byte    = 8'h00;
        byte_d.program_done = 1'b1;
        byte_d.status       = head_i.status;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= byte_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= x86e_pkg::PH_START;
      idx_q <= 4'd0;
      off_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      ph_q  <= ph_d;
      idx_q <= idx_d;
      off_q <= off_d;
      if (step) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/x86_64_code_emitter.sv
// Top level of the x86-64 code emitter: front end, descriptor queue, back end.
// Depends on x86e_pkg, x86e_front, x86e_queue and x86e_back.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   in_data_i (x86e_pkg::in_t)
//   out       output     out_valid_o/out_ready_i out_data_o (x86e_pkg::out_t)
//   cfg       input      cfg_we_i                cfg_wdata_i (buffer_size)
//
// The front takes one request per cycle while the four-entry queue has room.
// The back emits one byte per cycle while the output does not stall: a body is 1 to 9 bytes,
// plus 13 for a prologue and 11 for an epilogue; an error gives a single byte.
// Items that produce no bytes are taken by the front and never reach the queue.
// Reset puts buffer_size at 4096 and the emitter idle between programs.
// A stall on the output holds the back; the front keeps taking requests until the queue fills.
module x86_64_code_emitter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  x86e_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output x86e_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i
);

  logic            q_full, q_push, q_pop, q_valid;
  x86e_pkg::desc_t q_wdesc, q_rdesc;

  x86e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_desc_o    (q_wdesc)
  );

  x86e_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdesc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdesc)
  );

  x86e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hv_i        (q_valid),
    .head_i      (q_rdesc),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/x86e_checker.sv
// Port-level checker for the x86-64 code emitter, bound to the top level.
// Depends on x86e_pkg and on the port names of x86_64_code_emitter.
module x86e_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input x86e_pkg::out_t out_data_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // An error result ends both its run and its program.
  a_err_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != x86e_pkg::StatusOk) |->
      out_data_o.program_done && out_data_o.last_of_run)
    else $error("error result does not close the run");

  // The closing epilogue byte is ret and is the final byte of its request.
  a_done_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.program_done && (out_data_o.status == x86e_pkg::StatusOk) |->
      out_data_o.last_of_run && (out_data_o.code_byte == 8'hC3))
    else $error("program end is not a ret closing the run");

  // Within a run, consecutive bytes sit at consecutive offsets.
  a_offset_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run ##1 out_valid_o |->
      out_data_o.byte_offset == $past(out_data_o.byte_offset) + 1'b1)
    else $error("byte offsets are not contiguous");

endmodule

bind x86_64_code_emitter x86e_checker u_x86e_checker (.*);

// File: bench/x86_64_code_emitter_checker.sv
// Checker for the x86-64 code emitter: keeps its own copy of the emitter state, predicts
// the code bytes of every accepted request and compares them with the output channel.
// Depends on x86e_pkg for the payload structs and the command and status codes.
module x86_64_code_emitter_checker
  import x86e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          pending_o,
  output int          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Function entry and exit byte strings, first byte in the top bits.
  localparam logic [103:0] EntrySeq = 104'h55_48_89_E5_53_41_54_41_55_41_56_41_57;
  localparam logic [87:0]  ExitSeq  = 88'h41_5F_41_5E_41_5D_41_5C_5B_5D_C3;

  logic [15:0]     buf_size;
  logic [OffW-1:0] wr_off;
  logic [OffW-1:0] loop_mark;
  logic            in_prog;
  logic            skip_rest;
  out_t            item_bytes[$];
  out_t            expected_bytes[$];
  out_t            want;
  int              mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic void push_result(input logic [7:0] b, input logic [OffW-1:0] off,
                                      input logic done, input logic [1:0] st);
    out_t r;
    r.code_byte    = b;
    r.byte_offset  = off;
    r.last_of_run  = 1'b0;
    r.program_done = done;
    r.status       = st;
    item_bytes.push_back(r);
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    push_result(b, wr_off, 1'b0, StatusOk);
    wr_off = wr_off + 1'b1;
  endfunction

  function automatic void emit_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) emit_byte(w[8*k +: 8]);
  endfunction

  function automatic logic [7:0] rex_prefix(input logic [3:0] r_fld, input logic [3:0] m_fld);
    return RexW | {5'b0, r_fld[3], 1'b0, m_fld[3]};
  endfunction

  function automatic logic [7:0] modrm_direct(input logic [3:0] r_fld, input logic [3:0] m_fld);
    return {2'b11, r_fld[2:0], m_fld[2:0]};
  endfunction

  function automatic void emit_exit_seq();
    for (int i = 0; i < EpilogueLen; i++) begin
      push_result(ExitSeq[(EpilogueLen-1-i)*8 +: 8], wr_off, i == EpilogueLen - 1, StatusOk);
      wr_off = wr_off + 1'b1;
    end
  endfunction

  // An error ends the program; without the last mark the rest of it is dropped.
  function automatic void flag_error(input logic [OffW-1:0] off, input logic [1:0] st,
                                     input logic last);
    push_result(8'h00, off, 1'b1, st);
    in_prog   = !last;
    skip_rest = !last;
  endfunction

  function automatic void predict_request(input in_t req);
    logic stop;
    int   rel;
    out_t tail;
    item_bytes.delete();
    stop = 1'b0;
    if (in_prog && skip_rest) begin
      if (req.last_item) begin
        in_prog   = 1'b0;
        skip_rest = 1'b0;
      end
      return;
    end
    if (!in_prog) begin
      if (buf_size < MinBuffer) begin
        flag_error('0, StatusSmall, req.last_item);
        stop = 1'b1;
      end else begin
        in_prog   = 1'b1;
        skip_rest = 1'b0;
        wr_off    = '0;
        for (int i = 0; i < PrologueLen; i++) emit_byte(EntrySeq[(PrologueLen-1-i)*8 +: 8]);
        loop_mark = wr_off;
      end
    end
    if (!stop && (int'(wr_off) + Headroom >= int'(buf_size))) begin
      flag_error(wr_off, StatusOvf, req.last_item);
      stop = 1'b1;
    end
    if (!stop) begin
      case (req.command)
        CmdNop: emit_byte(8'h90);
        CmdMovImm: begin
          emit_byte(rex_prefix(4'd0, req.dest_reg));
          emit_byte(8'hC7);
          emit_byte(8'hC0 | req.dest_reg[2:0]);
          emit_word(req.immediate);
        end
        CmdMovReg: begin
          emit_byte(rex_prefix(req.src_reg, req.dest_reg));
          emit_byte(8'h89);
          emit_byte(modrm_direct(req.src_reg, req.dest_reg));
        end
        CmdAddImm: begin
          emit_byte(rex_prefix(4'd0, req.dest_reg));
          emit_byte(8'h81);
          emit_byte(8'hC0 | req.dest_reg[2:0]);
          emit_word(req.immediate);
        end
        CmdAddReg: begin
          emit_byte(rex_prefix(req.src_reg, req.dest_reg));
          emit_byte(8'h01);
          emit_byte(modrm_direct(req.src_reg, req.dest_reg));
        end
        CmdSubImm: begin
          // The reg field carries the opcode extension 5 of the group-1 form.
          emit_byte(rex_prefix(4'd5, req.dest_reg));
          emit_byte(8'h81);
          emit_byte(8'hE8 | req.dest_reg[2:0]);
          emit_word(req.immediate);
        end
        CmdSubReg: begin
          emit_byte(rex_prefix(req.src_reg, req.dest_reg));
          emit_byte(8'h29);
          emit_byte(modrm_direct(req.src_reg, req.dest_reg));
        end
        CmdMulReg: begin
          emit_byte(rex_prefix(req.dest_reg, req.src_reg));
          emit_byte(8'h0F);
          emit_byte(8'hAF);
          emit_byte(modrm_direct(req.dest_reg, req.src_reg));
        end
        CmdXorReg: begin
          emit_byte(rex_prefix(req.src_reg, req.dest_reg));
          emit_byte(8'h31);
          emit_byte(modrm_direct(req.src_reg, req.dest_reg));
        end
        CmdLoopStart: loop_mark = wr_off;
        CmdLoopDec: begin
          emit_byte(rex_prefix(4'd0, req.dest_reg));
          emit_byte(8'hFF);
          emit_byte(8'hC8 | req.dest_reg[2:0]);
          // Displacements count from the end of the jump instruction.
          rel = int'(loop_mark) - (int'(wr_off) + 2);
          if (rel >= -128 && rel <= 127) begin
            emit_byte(8'h75);
            emit_byte(rel[7:0]);
          end else begin
            rel = int'(loop_mark) - (int'(wr_off) + 6);
            emit_byte(8'h0F);
            emit_byte(8'h85);
            emit_word(rel);
          end
        end
        CmdFinish: begin
          emit_exit_seq();
          in_prog   = !req.last_item;
          skip_rest = !req.last_item;
          stop      = 1'b1;
        end
        default: ;
      endcase
    end
    if (!stop && req.last_item) begin
      emit_exit_seq();
      in_prog   = 1'b0;
      skip_rest = 1'b0;
    end
    if (item_bytes.size() > 0) begin
      tail = item_bytes.pop_back();
      tail.last_of_run = 1'b1;
      item_bytes.push_back(tail);
    end
    foreach (item_bytes[i]) expected_bytes.push_back(item_bytes[i]);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size  = 16'd4096;
      wr_off    = '0;
      loop_mark = OffW'(PrologueLen);
      in_prog   = 1'b0;
      skip_rest = 1'b0;
      expected_bytes.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) buf_size = cfg_wdata_i;
      // A request is predicted before any byte of the same edge is checked.
      if (in_valid_i && in_ready_i) predict_request(in_data_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected code byte %02h at offset %0d", out_data_i.code_byte,
                 out_data_i.byte_offset);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("code_byte", want.code_byte, out_data_i.code_byte);
          check_field("byte_offset", want.byte_offset, out_data_i.byte_offset);
          check_field("last_of_run", want.last_of_run, out_data_i.last_of_run);
          check_field("program_done", want.program_done, out_data_i.program_done);
          check_field("status", want.status, out_data_i.status);
        end
      end
      pending_o <= expected_bytes.size();
    end
  end

endmodule

// File: bench/x86_64_code_emitter_tb.sv
// Testbench top for the x86-64 code emitter: clock, reset, request stimulus, output
// back-pressure and the verdict. Depends on x86e_pkg, the emitter RTL and the checker.
module x86_64_code_emitter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import x86e_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int HoldLen       = 400;
  localparam int QuietCycles   = 16;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_t         in_data   = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int   pending;
  int   fail_count;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_go       = 1'b0;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;
  int   sent_count    = 0;

  always #5 clk = ~clk;

  x86_64_code_emitter u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  x86_64_code_emitter_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Output side: random stalls, plus one long hold-off when the stimulus asks for it.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      out_ready <= 1'b0;
      hold_left <= HoldLen;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic in_t request_of(input logic [3:0] cmd, input logic [3:0] d,
                                     input logic [3:0] s, input logic [31:0] imm,
                                     input logic last);
    in_t r;
    r.command   = cmd;
    r.dest_reg  = d;
    r.src_reg   = s;
    r.immediate = imm;
    r.last_item = last;
    return r;
  endfunction

  function automatic in_t random_request(input logic [3:0] cmd, input logic last);
    logic [31:0] imm;
    case ($urandom_range(3))
      0:       imm = '0;
      1:       imm = '1;
      default: imm = $urandom;
    endcase
    return request_of(cmd, 4'($urandom_range(15)), 4'($urandom_range(15)), imm, last);
  endfunction

  // Mostly real instructions, now and then one of the unused command codes.
  function automatic logic [3:0] pick_command();
    if ($urandom_range(11) == 0) return CmdFinish + 4'($urandom_range(1, 4));
    return 4'($urandom_range(CmdNop, CmdLoopDec));
  endfunction

  task automatic send_request(input in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Requests that emit nothing may still sit in the front end.
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic write_buffer_size(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One program: optional loop around the body, optional early finish with a dropped tail.
  task automatic send_program(input int body_len);
    logic with_loop;
    logic early_finish;
    with_loop    = (body_len > 20) || ($urandom_range(2) == 0);
    early_finish = ($urandom_range(9) == 0);
    if (with_loop) begin
      send_request(random_request(CmdLoopStart, 1'b0));
      sent_count++;
    end
    repeat (body_len) begin
      send_request(random_request(pick_command(), 1'b0));
      sent_count++;
    end
    if (with_loop) begin
      send_request(random_request(CmdLoopDec, 1'b0));
      sent_count++;
    end
    if (early_finish) begin
      send_request(random_request(CmdFinish, 1'b0));
      sent_count++;
      repeat ($urandom_range(3)) send_request(random_request(pick_command(), 1'b0));
    end
    send_request(random_request(($urandom_range(4) == 0) ? CmdFinish : pick_command(), 1'b1));
    sent_count++;
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      send_request(random_request(4'($urandom_range(15)), 1'($urandom_range(1))));
      sent_count++;
    end
  endtask

  task automatic run_phase(input logic [15:0] size, input int idle, input int stall,
                           input int target, input logic long_hold, input logic mid_drain);
    int phase_start;
    drain_results();
    write_buffer_size(size);
    send_idle_pct = idle;
    stall_pct    <= stall;
    if (long_hold) begin
      hold_go <= 1'b1;
      @(posedge clk);
      hold_go <= 1'b0;
    end
    phase_start = sent_count;
    while (sent_count - phase_start < target) begin
      if (mid_drain && (sent_count - phase_start >= target / 2)) begin
        drain_results();
        mid_drain = 1'b0;
      end
      if ($urandom_range(14) == 0) send_noise();
      else send_program(($urandom_range(5) == 0) ? $urandom_range(22, 36) : $urandom_range(6));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the reset buffer size, no idling on either side.
    send_request(request_of(CmdMovImm, 4'd0, 4'd0, 32'h0000_0000, 1'b0));
    send_request(request_of(CmdMovImm, 4'd15, 4'd0, 32'hFFFF_FFFF, 1'b0));
    send_request(request_of(CmdMovReg, 4'd15, 4'd0, 32'h0, 1'b0));
    send_request(request_of(CmdMovReg, 4'd0, 4'd15, 32'h0, 1'b0));
    send_request(request_of(CmdAddImm, 4'd8, 4'd0, 32'h8000_0001, 1'b0));
    send_request(request_of(CmdAddReg, 4'd7, 4'd8, 32'h0, 1'b0));
    send_request(request_of(CmdSubImm, 4'd9, 4'd0, 32'h1234_5678, 1'b0));
    send_request(request_of(CmdSubReg, 4'd3, 4'd12, 32'h0, 1'b0));
    send_request(request_of(CmdMulReg, 4'd12, 4'd5, 32'h0, 1'b0));
    send_request(request_of(CmdMulReg, 4'd2, 4'd13, 32'h0, 1'b0));
    send_request(request_of(CmdXorReg, 4'd15, 4'd15, 32'h0, 1'b0));
    send_request(request_of(CmdNop, 4'd0, 4'd0, 32'h0, 1'b0));
    send_request(request_of(CmdLoopStart, 4'd0, 4'd0, 32'h0, 1'b0));
    send_request(request_of(CmdFinish + 4'd1, 4'd0, 4'd0, 32'h0, 1'b0));
    send_request(request_of(CmdFinish + 4'd4, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b0));
    send_request(request_of(CmdLoopDec, 4'd10, 4'd0, 32'h0, 1'b0));
    send_request(request_of(CmdNop, 4'd0, 4'd0, 32'h0, 1'b1));
    // Finish as the only request of a program.
    send_request(request_of(CmdFinish, 4'd0, 4'd0, 32'h0, 1'b1));
    // Finish before the end: the rest up to the last mark is dropped.
    send_request(request_of(CmdFinish, 4'd0, 4'd0, 32'h0, 1'b0));
    send_request(request_of(CmdMovImm, 4'd1, 4'd0, 32'hA5A5_A5A5, 1'b0));
    send_request(request_of(CmdFinish + 4'd2, 4'd0, 4'd0, 32'h0, 1'b1));
    // Requests that open or close a program; the first two emit nothing themselves.
    send_request(request_of(CmdLoopStart, 4'd0, 4'd0, 32'h0, 1'b1));
    send_request(request_of(CmdFinish + 4'd3, 4'd0, 4'd0, 32'h0, 1'b0));
    send_request(request_of(CmdLoopDec, 4'd1, 4'd0, 32'h0, 1'b1));

    run_phase(16'hFFFF, 0, 0, 40, 1'b1, 1'b0);
    run_phase(16'd63, 72, 0, 15, 1'b0, 1'b0);
    run_phase(16'd64, 0, 72, 25, 1'b0, 1'b0);
    run_phase(16'd0, 14, 14, 10, 1'b0, 1'b0);
    run_phase(16'd200, 72, 0, 30, 1'b0, 1'b0);
    run_phase(16'd1000, 0, 72, 40, 1'b0, 1'b1);
    run_phase(16'($urandom_range(64, 2000)), 14, 14, 40, 1'b0, 1'b0);
    run_phase(16'd4096, 0, 0, 40, 1'b0, 1'b0);

    drain_results();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
